// ===== rtl/mavg_pkg.sv =====
package mavg_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  // window_length register width is fixed by the register map
  localparam int WIN_BITS    = 7;
  localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(4);

  localparam int SLOT_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RING_DEPTH  = 2 ** SLOT_BITS;
  localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
  localparam int CNT_BITS    = $clog2(SUM_BITS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_of_set;
    logic                          last_of_set;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          too_short;
    logic                          end_of_set;
  } out_word_t;

  // queue entry between front and back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
    logic                          close;
  } queue_word_t;

  // zero acts as one, anything above MAX_WINDOW saturates to MAX_WINDOW
  function automatic logic [WIN_BITS-1:0] eff_window(logic [WIN_BITS-1:0] wl);
    logic [WIN_BITS-1:0] w;
    w = wl;
    if (wl == '0) begin
      w = WIN_BITS'(1);
    end else if (32'(wl) > MAX_WINDOW) begin
      w = WIN_BITS'(MAX_WINDOW);
    end
    return w;
  endfunction

endpackage

// ===== rtl/moving_average_filter_top.sv =====
// An accepted word goes from IDLE to UPDATE; once the window is full it waits in DIVIDE for
//   the bit-serial divider, then RESULT; a too-short result goes from UPDATE to RESULT.
// A word that gives no result returns from UPDATE to IDLE. A new word is taken only in IDLE;
//   a two-word queue keeps taking input meanwhile.
// Reset (rst, synchronous): window length 4, sum, fill count and ring slot cleared;
//   the sample ring is not cleared and is only read where written in the current set.
module moving_average_filter_top import mavg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WIN_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_data
);

  logic        q_valid;
  logic        q_ready;
  queue_word_t q_data;

  mavg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  mavg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_short_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_short |-> out_data.end_of_set && out_data.average == '0)
    else $error("too-short result without end of set or with non-zero average");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word present straight after reset");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst))
    else $error("result word raised while in reset");
`endif

endmodule

// ===== rtl/mavg_ram.sv =====
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mavg_front.sv =====
module mavg_front import mavg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        q_valid,
  input  logic        q_ready,
  output queue_word_t q_data
);

  queue_word_t          entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;
  queue_word_t          classified;

  assign in_ready = (count != (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_data   = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    classified.sample  = in_data.sample;
    classified.restart = in_data.first_of_set;
    classified.close   = in_data.last_of_set;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mavg_div.sv =====
module mavg_div import mavg_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SUM_BITS-1:0]    dividend,
  input  logic [WIN_BITS-1:0]           divisor,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  logic                busy;
  logic [CNT_BITS-1:0] steps;
  logic [SUM_BITS-1:0] quo;
  logic [WIN_BITS-1:0] rem;
  logic [WIN_BITS-1:0] dvs;
  logic                neg;
  logic [WIN_BITS:0]   trial;
  logic                fits;
  logic [SAMPLE_BITS-1:0] mag;

  // restoring division, one quotient bit a cycle, on the magnitude
  assign trial = {rem, quo[SUM_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign mag   = quo[SAMPLE_BITS-1:0];
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : dividend;
      neg <= dividend[SUM_BITS-1];
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? WIN_BITS'(trial - {1'b0, dvs}) : trial[WIN_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_BITS'(SUM_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mavg_back.sv =====
module mavg_back import mavg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WIN_BITS-1:0] cfg_data,
  input  logic                q_valid,
  output logic                q_ready,
  input  queue_word_t         q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_data
);

  typedef enum logic [1:0] {
    IDLE,
    UPDATE,
    DIVIDE,
    RESULT
  } state_t;

  state_t state;

  logic [WIN_BITS-1:0]        window_length;
  logic [WIN_BITS-1:0]        fill_count;
  logic signed [SUM_BITS-1:0] running_sum;
  logic [SLOT_BITS-1:0]       write_slot;

  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic                          cur_last;
  logic [WIN_BITS-1:0]           cur_fill;
  logic signed [SUM_BITS-1:0]    cur_sum;
  logic [WIN_BITS-1:0]           cur_eff;

  logic [WIN_BITS-1:0]        eff;
  logic [SLOT_BITS:0]         eff_ext;
  logic [SLOT_BITS-1:0]       oldest;
  logic [SAMPLE_BITS-1:0]     ring_rdata;
  logic                       ring_we;
  logic                       accept;
  logic                       full;
  logic signed [SUM_BITS-1:0] old_ext;
  logic signed [SUM_BITS-1:0] smp_ext;
  logic signed [SUM_BITS-1:0] new_sum;
  logic [WIN_BITS-1:0]        new_fill;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_BITS-1:0] div_quotient;

  // take a new window length only while no word is queued or being worked on
  assign cfg_ready = (state == IDLE) && !q_valid;
  assign q_ready   = (state == IDLE);
  assign accept    = q_valid && q_ready;

  assign eff     = eff_window(window_length);
  assign eff_ext = (SLOT_BITS + 1)'(eff);
  assign oldest  = write_slot - eff_ext[SLOT_BITS-1:0];

  // slide the window once it is full, else grow it
  assign full     = (cur_fill >= cur_eff);
  assign old_ext  = SUM_BITS'($signed(ring_rdata));
  assign smp_ext  = SUM_BITS'(cur_sample);
  assign new_sum  = full ? cur_sum - old_ext + smp_ext : cur_sum + smp_ext;
  assign new_fill = full ? cur_eff : cur_fill + 1'b1;

  assign ring_we   = (state == UPDATE);
  assign div_start = (state == UPDATE) && (new_fill == cur_eff);

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (cur_sample),
    .raddr (oldest),
    .rdata (ring_rdata)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (cur_eff),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample <= q_data.sample;
      cur_last   <= q_data.close;
      cur_fill   <= q_data.restart ? '0 : fill_count;
      cur_sum    <= q_data.restart ? '0 : running_sum;
      cur_eff    <= eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      window_length <= WIN_RESET;
      fill_count    <= '0;
      running_sum   <= '0;
      write_slot    <= '0;
      out_valid     <= 1'b0;
      out_data      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_length <= cfg_data;
        fill_count    <= '0;
        running_sum   <= '0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          write_slot  <= write_slot + 1'b1;
          // drop the set state after its last word
          fill_count  <= cur_last ? '0 : new_fill;
          running_sum <= cur_last ? '0 : new_sum;
          if (new_fill == cur_eff) begin
            state <= DIVIDE;
          end else if (cur_last) begin
            out_data.average    <= '0;
            out_data.too_short  <= 1'b1;
            out_data.end_of_set <= 1'b1;
            out_valid           <= 1'b1;
            state               <= RESULT;
          end else begin
            state <= IDLE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            out_data.average    <= div_quotient;
            out_data.too_short  <= 1'b0;
            out_data.end_of_set <= cur_last;
            out_valid           <= 1'b1;
            state               <= RESULT;
          end
        end
        RESULT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
